### src/cts_pkg.sv
// shared types and constants of the can transmit supervisor
package cts_pkg;

  // event kinds
  localparam logic [1:0] KIND_SEND   = 2'd0;
  localparam logic [1:0] KIND_BEAT   = 2'd1;
  localparam logic [1:0] KIND_HEALTH = 2'd2;
  localparam logic [1:0] KIND_RESET  = 2'd3;

  // send status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BUSY  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_BEAT_PERIOD   = 2'd0;
  localparam logic [1:0] CFG_STALL_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_BEAT_ID       = 2'd2;

  // configuration reset values
  localparam logic [15:0] BEAT_PERIOD_RST   = 16'd100;
  localparam logic [15:0] STALL_TIMEOUT_RST = 16'd100;
  localparam logic [10:0] BEAT_ID_RST       = 11'd0;

  // largest legal data length code
  localparam logic [3:0] MAX_DLC = 4'd8;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now_ms;
    logic [10:0] std_id;
    logic [3:0]  dlc;
    logic        data_present;
    logic        controller_listening;
    logic        mailbox_free;
    logic        queue_accepted;
    logic [31:0] controller_error;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  send_status;
    logic        frame_issued;
    logic [10:0] frame_id;
    logic [3:0]  frame_length;
    logic        healthy;
    logic        abort_all;
    logic [31:0] sent_total;
    logic [31:0] error_total;
    logic [31:0] busy_total;
    logic [31:0] stall_total;
    logic [31:0] last_error_flags;
    logic        last_failed;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  addr;
    logic [15:0] wdata;
  } cfg_item_t;

endpackage

### src/cts_if.sv
// valid/ready channel interfaces of the can transmit supervisor

interface cts_in_if;
  logic               valid;
  logic               ready;
  cts_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cts_out_if;
  logic               valid;
  logic               ready;
  cts_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cts_cfg_if;
  logic               valid;
  logic               ready;
  cts_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/can_tx_supervisor.sv
// top level of the can transmit supervisor
//
// Usage:
// - in_i carries one event per transfer: send request, heartbeat tick,
//   health check or diagnostics reset, with the controller status bits.
// - out_o returns exactly one result per event, in order, holding the
//   send outcome, the issued frame, the health flags and all counters.
// - cfg_i writes heartbeat period, stall timeout and heartbeat id; it is
//   always ready and should only be used while no result is pending.
// Each result is registered in the output entry, or in the skid entry.
// Throughput: one event per cycle; the whole update is one pass of adds
// and compares between the accepted input and the result register.
// A two-entry result buffer (output register plus skid register) lets an
// event be taken while one result waits; in_i.ready drops only when both
// entries are full because the receiver stalls.
// Reset (rst_ni low): counters, deadline, busy timing and flags clear,
// configuration returns to period 100, timeout 100, id 0, and both
// result entries empty. No clearing pass is needed.

module can_tx_supervisor (
  input  logic clk_i,
  input  logic rst_ni,
  cts_in_if.sink    in_i,
  cts_out_if.source out_o,
  cts_cfg_if.sink   cfg_i
);
  import cts_pkg::*;

  // configuration registers
  logic [15:0] beat_period_q;
  logic [15:0] stall_timeout_q;
  logic [10:0] beat_id_q;

  // supervisor state
  logic [31:0] next_beat_q, next_beat_d;
  logic [31:0] busy_start_q, busy_start_d;
  logic        busy_flag_q, busy_flag_d;
  logic [31:0] sent_cnt_q, sent_cnt_d;
  logic [31:0] err_cnt_q, err_cnt_d;
  logic [31:0] busy_cnt_q, busy_cnt_d;
  logic [31:0] stall_cnt_q, stall_cnt_d;
  logic [31:0] err_flags_q, err_flags_d;
  logic        failed_q, failed_d;

  // result buffer
  out_item_t out_q, skid_q, res;
  logic      out_vld_q, skid_vld_q;

  logic        in_fire, out_fire;
  logic        do_send;
  logic [10:0] s_id;
  logic [3:0]  s_dlc;
  logic        s_data;
  logic [31:0] beat_adv, beat_diff0, beat_diff1, busy_age;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !skid_vld_q;
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_fire    = out_vld_q && out_o.ready;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_period_q   <= BEAT_PERIOD_RST;
      stall_timeout_q <= STALL_TIMEOUT_RST;
      beat_id_q       <= BEAT_ID_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.addr)
        CFG_BEAT_PERIOD:   beat_period_q   <= cfg_i.data.wdata;
        CFG_STALL_TIMEOUT: stall_timeout_q <= cfg_i.data.wdata;
        CFG_BEAT_ID:       beat_id_q       <= cfg_i.data.wdata[10:0];
        default: ;
      endcase
    end
  end

  // wrap-safe time differences
  assign beat_diff0 = in_i.data.now_ms - next_beat_q;
  assign beat_adv   = next_beat_q + {16'd0, beat_period_q};
  assign beat_diff1 = in_i.data.now_ms - beat_adv;
  assign busy_age   = in_i.data.now_ms - busy_start_q;

  // event evaluation
  always_comb begin
    next_beat_d  = next_beat_q;
    busy_start_d = busy_start_q;
    busy_flag_d  = busy_flag_q;
    sent_cnt_d   = sent_cnt_q;
    err_cnt_d    = err_cnt_q;
    busy_cnt_d   = busy_cnt_q;
    stall_cnt_d  = stall_cnt_q;
    err_flags_d  = err_flags_q;
    failed_d     = failed_q;
    do_send      = 1'b0;
    s_id         = in_i.data.std_id;
    s_dlc        = in_i.data.dlc;
    s_data       = in_i.data.data_present;
    res              = '0;
    res.send_status  = ST_OK;
    res.healthy      = 1'b1;

    case (in_i.data.kind)
      KIND_SEND: begin
        do_send = 1'b1;
      end
      KIND_BEAT: begin
        if (!beat_diff0[31]) begin
          if (!beat_diff1[31]) begin
            next_beat_d = in_i.data.now_ms + {16'd0, beat_period_q};
          end else begin
            next_beat_d = beat_adv;
          end
          do_send = 1'b1;
          s_id    = beat_id_q;
          s_dlc   = '0;
          s_data  = 1'b0;
        end
      end
      KIND_HEALTH: begin
        if (busy_flag_q && (busy_age >= {16'd0, stall_timeout_q})) begin
          err_flags_d   = in_i.data.controller_error;
          stall_cnt_d   = stall_cnt_q + 32'd1;
          busy_flag_d   = 1'b0;
          res.healthy   = 1'b0;
          res.abort_all = 1'b1;
        end
      end
      KIND_RESET: begin
        sent_cnt_d   = '0;
        err_cnt_d    = '0;
        busy_cnt_d   = '0;
        err_flags_d  = '0;
        failed_d     = 1'b0;
        next_beat_d  = in_i.data.now_ms;
        busy_start_d = '0;
        busy_flag_d  = 1'b0;
      end
      default: ;
    endcase

    // send attempt checks in order
    if (do_send) begin
      if ((s_dlc > MAX_DLC) || ((s_dlc != '0) && !s_data) ||
          !in_i.data.controller_listening) begin
        failed_d        = 1'b1;
        err_cnt_d       = err_cnt_q + 32'd1;
        res.send_status = ST_ERROR;
      end else if (!in_i.data.mailbox_free) begin
        if (!busy_flag_q) begin
          busy_flag_d  = 1'b1;
          busy_start_d = in_i.data.now_ms;
        end
        busy_cnt_d      = busy_cnt_q + 32'd1;
        res.send_status = ST_BUSY;
      end else begin
        busy_flag_d = 1'b0;
        err_flags_d = in_i.data.controller_error;
        if (!in_i.data.queue_accepted) begin
          failed_d        = 1'b1;
          err_cnt_d       = err_cnt_q + 32'd1;
          res.send_status = ST_ERROR;
        end else begin
          failed_d         = 1'b0;
          sent_cnt_d       = sent_cnt_q + 32'd1;
          res.frame_issued = 1'b1;
          res.frame_id     = s_id;
          res.frame_length = s_dlc;
        end
      end
    end

    res.sent_total       = sent_cnt_d;
    res.error_total      = err_cnt_d;
    res.busy_total       = busy_cnt_d;
    res.stall_total      = stall_cnt_d;
    res.last_error_flags = err_flags_d;
    res.last_failed      = failed_d;
  end

  // state update on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_beat_q  <= '0;
      busy_start_q <= '0;
      busy_flag_q  <= 1'b0;
      sent_cnt_q   <= '0;
      err_cnt_q    <= '0;
      busy_cnt_q   <= '0;
      stall_cnt_q  <= '0;
      err_flags_q  <= '0;
      failed_q     <= 1'b0;
    end else if (in_fire) begin
      next_beat_q  <= next_beat_d;
      busy_start_q <= busy_start_d;
      busy_flag_q  <= busy_flag_d;
      sent_cnt_q   <= sent_cnt_d;
      err_cnt_q    <= err_cnt_d;
      busy_cnt_q   <= busy_cnt_d;
      stall_cnt_q  <= stall_cnt_d;
      err_flags_q  <= err_flags_d;
      failed_q     <= failed_d;
    end
  end

  // result buffer valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_fire) begin
        skid_vld_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_vld_q && !out_o.ready) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_vld_q <= 1'b0;
    end
  end

  // result buffer payload
  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (out_vld_q && !out_o.ready) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  // skid entry is only ever occupied behind a held output entry
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry valid without output entry");

  // a transfer into a stalled output must land in the skid entry
  a_stall_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && out_vld_q && !out_o.ready) |=> skid_vld_q)
    else $error("result lost while receiver stalled");

  // an issued frame always reports ok
  a_issue_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.frame_issued) |-> (out_q.send_status == ST_OK))
    else $error("issued frame with non-ok status");

  // a stall both clears health and asks for abort, and never issues a frame
  a_stall_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((out_q.abort_all == !out_q.healthy) &&
                   !(out_q.abort_all && out_q.frame_issued)))
    else $error("inconsistent stall flags");

endmodule

### verif/can_tx_supervisor_test.sv
`timescale 1ns / 100ps
// self-checking testbench of the can transmit supervisor, with its own predictor
module can_tx_supervisor_test;
  import cts_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int PHASE_ITEMS = 317;
  localparam int MAX_PRINTS  = 40;

  // predicts every result from accepted events and checks the results in order
  class supervisor_scoreboard;
    logic [15:0] beat_period;
    logic [15:0] stall_timeout;
    logic [10:0] beat_id;
    logic [31:0] next_beat;
    logic [31:0] busy_start;
    bit          busy_on;
    logic [31:0] sent_cnt;
    logic [31:0] err_cnt;
    logic [31:0] busy_cnt;
    logic [31:0] stall_cnt;
    logic [31:0] err_flags;
    bit          failed;
    out_item_t   expected_results[$];
    int          mismatches;
    int          n_checked;
    int          n_kind[4];
    int          n_issued;
    int          n_stalls;

    function new();
      beat_period   = BEAT_PERIOD_RST;
      stall_timeout = STALL_TIMEOUT_RST;
      beat_id       = BEAT_ID_RST;
      next_beat     = '0;
      busy_start    = '0;
      busy_on       = 1'b0;
      sent_cnt      = '0;
      err_cnt       = '0;
      busy_cnt      = '0;
      stall_cnt     = '0;
      err_flags     = '0;
      failed        = 1'b0;
      mismatches    = 0;
      n_checked     = 0;
      n_issued      = 0;
      n_stalls      = 0;
      foreach (n_kind[k]) n_kind[k] = 0;
    endfunction

    function void write_register(logic [1:0] index, logic [15:0] value);
      case (index)
        CFG_BEAT_PERIOD:   beat_period   = value;
        CFG_STALL_TIMEOUT: stall_timeout = value;
        CFG_BEAT_ID:       beat_id       = value[10:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // wrap-safe compare: deadline reached while the difference is not negative
    function bit deadline_reached(logic [31:0] now, logic [31:0] deadline);
      logic [31:0] diff;
      diff = now - deadline;
      return !diff[31];
    endfunction

    // one send attempt, shared by send requests and heartbeat frames
    function void attempt_send(in_item_t ev, logic [10:0] id, logic [3:0] dlc,
                               bit with_data, inout out_item_t res);
      res.frame_issued = 1'b0;
      res.frame_id     = '0;
      res.frame_length = '0;
      if (dlc > MAX_DLC || (dlc != 4'd0 && !with_data) || !ev.controller_listening) begin
        failed = 1'b1;
        err_cnt++;
        res.send_status = ST_ERROR;
      end else if (!ev.mailbox_free) begin
        if (!busy_on) begin
          busy_on    = 1'b1;
          busy_start = ev.now_ms;
        end
        busy_cnt++;
        res.send_status = ST_BUSY;
      end else begin
        busy_on   = 1'b0;
        err_flags = ev.controller_error;
        if (!ev.queue_accepted) begin
          failed = 1'b1;
          err_cnt++;
          res.send_status = ST_ERROR;
        end else begin
          failed = 1'b0;
          sent_cnt++;
          res.send_status  = ST_OK;
          res.frame_issued = 1'b1;
          res.frame_id     = id;
          res.frame_length = dlc;
        end
      end
    endfunction

    function void note_event(in_item_t ev);
      out_item_t res;
      res             = '0;
      res.send_status = ST_OK;
      res.healthy     = 1'b1;
      n_kind[ev.kind]++;
      case (ev.kind)
        KIND_SEND: attempt_send(ev, ev.std_id, ev.dlc, ev.data_present, res);
        KIND_BEAT: begin
          if (deadline_reached(ev.now_ms, next_beat)) begin
            next_beat = next_beat + {16'd0, beat_period};
            // resynchronise when the deadline fell behind
            if (deadline_reached(ev.now_ms, next_beat))
              next_beat = ev.now_ms + {16'd0, beat_period};
            attempt_send(ev, beat_id, 4'd0, 1'b0, res);
          end
        end
        KIND_HEALTH: begin
          if (busy_on && (ev.now_ms - busy_start) >= {16'd0, stall_timeout}) begin
            err_flags = ev.controller_error;
            stall_cnt++;
            busy_on       = 1'b0;
            res.healthy   = 1'b0;
            res.abort_all = 1'b1;
          end
        end
        default: begin
          // diagnostics reset keeps the stall count
          sent_cnt   = '0;
          err_cnt    = '0;
          busy_cnt   = '0;
          err_flags  = '0;
          failed     = 1'b0;
          next_beat  = ev.now_ms;
          busy_start = '0;
          busy_on    = 1'b0;
        end
      endcase
      res.sent_total       = sent_cnt;
      res.error_total      = err_cnt;
      res.busy_total       = busy_cnt;
      res.stall_total      = stall_cnt;
      res.last_error_flags = err_flags;
      res.last_failed      = failed;
      if (res.frame_issued) n_issued++;
      if (res.abort_all) n_stalls++;
      expected_results.push_back(res);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= MAX_PRINTS)
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report(name, got, want);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        report("result with nothing expected", got.sent_total, '0);
        return;
      end
      want = expected_results.pop_front();
      n_checked++;
      compare_field("send_status", 32'(got.send_status), 32'(want.send_status));
      compare_field("frame_issued", 32'(got.frame_issued), 32'(want.frame_issued));
      compare_field("frame_id", 32'(got.frame_id), 32'(want.frame_id));
      compare_field("frame_length", 32'(got.frame_length), 32'(want.frame_length));
      compare_field("healthy", 32'(got.healthy), 32'(want.healthy));
      compare_field("abort_all", 32'(got.abort_all), 32'(want.abort_all));
      compare_field("sent_total", got.sent_total, want.sent_total);
      compare_field("error_total", got.error_total, want.error_total);
      compare_field("busy_total", got.busy_total, want.busy_total);
      compare_field("stall_total", got.stall_total, want.stall_total);
      compare_field("last_error_flags", got.last_error_flags, want.last_error_flags);
      compare_field("last_failed", 32'(got.last_failed), 32'(want.last_failed));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  cts_in_if  in_ch ();
  cts_out_if out_ch ();
  cts_cfg_if cfg_ch ();

  supervisor_scoreboard sb = new();

  int          sender_idle_pct   = 31;
  int          receiver_idle_pct = 57;
  logic [31:0] sim_now;

  can_tx_supervisor uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // clock
  always #4 clk_i = ~clk_i;

  // result receiver with random stalls, checks every result transfer
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
      out_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
    $display("** can_tx_supervisor: FAILED **");
    $finish;
  end

  // one event transfer, with random idle cycles ahead of it
  task automatic push_event(in_item_t ev);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= ev;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_event(ev);
  endtask

  // sender holds off until every expected result has arrived
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic program_register(logic [1:0] index, logic [15:0] value);
    cfg_item_t w;
    w.addr  = index;
    w.wdata = value;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= w;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    sb.write_register(index, value);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(logic [15:0] period, logic [15:0] timeout, logic [10:0] id);
    program_register(CFG_BEAT_PERIOD, period);
    program_register(CFG_STALL_TIMEOUT, timeout);
    program_register(CFG_BEAT_ID, {5'd0, id});
  endtask

  function automatic in_item_t make_event(logic [1:0] kind, logic [31:0] now,
                                          logic [10:0] id, logic [3:0] dlc, bit data,
                                          bit listen, bit free, bit accepted,
                                          logic [31:0] cerr);
    in_item_t ev;
    ev.kind                 = kind;
    ev.now_ms               = now;
    ev.std_id               = id;
    ev.dlc                  = dlc;
    ev.data_present         = data;
    ev.controller_listening = listen;
    ev.mailbox_free         = free;
    ev.queue_accepted       = accepted;
    ev.controller_error     = cerr;
    return ev;
  endfunction

  // mostly well-formed events on a slowly advancing clock, some noise and jumps
  function automatic in_item_t random_event();
    in_item_t ev;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 90) sim_now = sim_now + $urandom_range(0, 40);
    else if (pick < 97) sim_now = sim_now + $urandom_range(0, 70000);
    else sim_now = $urandom;
    pick = $urandom_range(0, 99);
    ev.kind   = (pick < 50) ? KIND_SEND : (pick < 75) ? KIND_BEAT :
                (pick < 95) ? KIND_HEALTH : KIND_RESET;
    ev.now_ms = sim_now;
    ev.std_id = 11'($urandom_range(0, 2047));
    if ($urandom_range(0, 99) < 15) begin
      ev.dlc                  = 4'($urandom_range(0, 15));
      ev.data_present         = 1'($urandom_range(0, 1));
      ev.controller_listening = 1'($urandom_range(0, 1));
      ev.mailbox_free         = 1'($urandom_range(0, 1));
      ev.queue_accepted       = 1'($urandom_range(0, 1));
      ev.controller_error     = $urandom;
    end else begin
      ev.dlc                  = 4'($urandom_range(0, 8));
      ev.data_present         = (ev.dlc != 4'd0) ? 1'b1 : 1'($urandom_range(0, 1));
      ev.controller_listening = ($urandom_range(0, 99) < 95);
      ev.mailbox_free         = ($urandom_range(0, 99) < 70);
      ev.queue_accepted       = ($urandom_range(0, 99) < 85);
      ev.controller_error     = ($urandom_range(0, 99) < 70) ? 32'd0 : $urandom;
    end
    return ev;
  endfunction

  task automatic run_random(int count, int tx_pct, int rx_pct);
    sender_idle_pct   = tx_pct;
    receiver_idle_pct = rx_pct;
    for (int i = 0; i < count; i++) begin
      push_event(random_event());
      if (i == count / 3 || $urandom_range(0, 99) < 2) wait_for_results();
    end
    wait_for_results();
  endtask

  // stimulus
  initial begin
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    rst_ni       <= 1'b0;
    sim_now = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // send checks in order, with reset configuration
    push_event(make_event(KIND_SEND, 32'd10, 11'h7FF, 4'd15, 1, 1, 1, 1, 32'hFFFF_FFFF));
    push_event(make_event(KIND_SEND, 32'd11, 11'h000, 4'd9, 1, 1, 1, 1, 32'h0));
    push_event(make_event(KIND_SEND, 32'd12, 11'h123, 4'd8, 1, 1, 1, 1, 32'h0));
    push_event(make_event(KIND_SEND, 32'd13, 11'h456, 4'd0, 0, 1, 1, 1, 32'h0));
    push_event(make_event(KIND_SEND, 32'd14, 11'h001, 4'd3, 0, 1, 1, 1, 32'h0));
    push_event(make_event(KIND_SEND, 32'd15, 11'h002, 4'd2, 1, 0, 1, 1, 32'h0));
    // busy starts timing once, then health checks before and at the timeout
    push_event(make_event(KIND_SEND, 32'd20, 11'h003, 4'd1, 1, 1, 0, 1, 32'h0));
    push_event(make_event(KIND_SEND, 32'd30, 11'h004, 4'd1, 1, 1, 0, 1, 32'h0));
    push_event(make_event(KIND_HEALTH, 32'd110, 11'h0, 4'd0, 0, 1, 1, 1, 32'h1111_1111));
    push_event(make_event(KIND_HEALTH, 32'd120, 11'h0, 4'd0, 0, 1, 1, 1, 32'hA5A5_A5A5));
    push_event(make_event(KIND_HEALTH, 32'd500, 11'h0, 4'd0, 0, 1, 1, 1, 32'h5A5A_5A5A));
    // frame refused by the controller records its error flags
    push_event(make_event(KIND_SEND, 32'd501, 11'h005, 4'd4, 1, 1, 1, 0, 32'h1234_5678));
    // heartbeat: late deadline resynchronises, early tick, busy, far jump
    push_event(make_event(KIND_BEAT, 32'd502, 11'h0, 4'd0, 0, 1, 1, 1, 32'h0));
    push_event(make_event(KIND_BEAT, 32'd601, 11'h0, 4'd0, 0, 1, 1, 1, 32'h0));
    push_event(make_event(KIND_BEAT, 32'd602, 11'h0, 4'd0, 0, 1, 0, 1, 32'h0));
    push_event(make_event(KIND_BEAT, 32'd2000, 11'h0, 4'd0, 0, 1, 1, 1, 32'h0));
    // diagnostics reset near the wrap of the millisecond clock
    push_event(make_event(KIND_RESET, 32'hFFFF_FFC0, 11'h0, 4'd0, 0, 1, 1, 1, 32'h0));
    push_event(make_event(KIND_BEAT, 32'hFFFF_FFC0, 11'h0, 4'd0, 0, 1, 1, 1, 32'h0));
    push_event(make_event(KIND_BEAT, 32'h0000_0010, 11'h0, 4'd0, 0, 1, 1, 1, 32'h0));
    push_event(make_event(KIND_BEAT, 32'h0000_0030, 11'h0, 4'd0, 0, 1, 1, 1, 32'h0));
    push_event(make_event(KIND_SEND, 32'h0000_0031, 11'h006, 4'd0, 0, 1, 0, 1, 32'h0));
    push_event(make_event(KIND_HEALTH, 32'h0000_0031, 11'h0, 4'd0, 0, 1, 1, 1, 32'h0));
    push_event(make_event(KIND_SEND, 32'h0000_0040, 11'h555, 4'd8, 1, 1, 1, 1, 32'h8000_0001));
    wait_for_results();

    // zero period and zero timeout
    configure(16'd0, 16'd0, 11'h7FF);
    push_event(make_event(KIND_BEAT, 32'd5000, 11'h0, 4'd0, 0, 1, 1, 1, 32'h0));
    push_event(make_event(KIND_BEAT, 32'd5000, 11'h0, 4'd0, 0, 1, 1, 1, 32'h0));
    push_event(make_event(KIND_SEND, 32'd5001, 11'h2AA, 4'd5, 1, 1, 0, 1, 32'h0));
    push_event(make_event(KIND_HEALTH, 32'd5001, 11'h0, 4'd0, 0, 1, 1, 1, 32'h7FFF_FFFE));
    wait_for_results();

    // random phases over extreme and random settings
    configure(16'd1, 16'd65535, 11'h555);
    sim_now = $urandom;
    run_random(PHASE_ITEMS, 31, 57);
    configure(16'd65535, 16'd1, 11'h2AA);
    run_random(PHASE_ITEMS, 57, 31);
    configure(16'($urandom_range(1, 300)), 16'($urandom_range(1, 300)),
              11'($urandom_range(0, 2047)));
    run_random(PHASE_ITEMS, 0, 0);
    repeat (8) @(posedge clk_i);

    if (sb.pending() != 0) sb.report("expectations left at end", sb.pending(), '0);
    $display("covered %0d events: %0d send, %0d heartbeat, %0d health, %0d diag reset",
             sb.n_kind[KIND_SEND] + sb.n_kind[KIND_BEAT] + sb.n_kind[KIND_HEALTH] +
             sb.n_kind[KIND_RESET], sb.n_kind[KIND_SEND], sb.n_kind[KIND_BEAT],
             sb.n_kind[KIND_HEALTH], sb.n_kind[KIND_RESET]);
    $display("%0d results checked, %0d frames issued, %0d stalls, %0d mismatches",
             sb.n_checked, sb.n_issued, sb.n_stalls, sb.mismatches);
    if (sb.mismatches == 0)
      $display("** can_tx_supervisor: PASSED **");
    else
      $display("** can_tx_supervisor: FAILED **");
    $finish;
  end

endmodule

### can_tx_supervisor.f
src/cts_pkg.sv
src/cts_if.sv
src/can_tx_supervisor.sv
verif/can_tx_supervisor_test.sv
